// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the PPM decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset.
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition that must never hold on a clock edge.
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_PROP(lbl, !(expr), msg)

`endif

// ----- rtl/core/rppm_pkg.sv -----
// Package with types and constants of the PPM frame decoder.
package rppm_pkg;

	localparam int MAX_CHANNELS  = 16;
	localparam int CH_IDX_BITS   = $clog2(MAX_CHANNELS);
	localparam int COUNTER_BITS  = 16;
	localparam int CMP_BITS      = 24;
	localparam int STORE_BITS    = 12;
	localparam int FIELD_CH_BITS = 4;
	localparam int VALUE_BITS    = 13;
	localparam int WD_BITS       = 24;
	localparam int CFG_DATA_BITS = 24;
	localparam int CFG_IDX_BITS  = 2;

	localparam logic [COUNTER_BITS-1:0] CNT_MAX   = {COUNTER_BITS{1'b1}};
	localparam logic [STORE_BITS-1:0]   STORE_MAX = {STORE_BITS{1'b1}};
	localparam logic [CH_IDX_BITS-1:0]  CH_LAST   = CH_IDX_BITS'(MAX_CHANNELS - 1);

	localparam logic [15:0]         SYNC_RST   = 16'd3000;
	localparam logic [15:0]         LOST_RST   = 16'd50000;
	localparam logic [11:0]         ZERO_RST   = 12'd1500;
	localparam logic [WD_BITS-1:0]  PERIOD_RST = 24'd3000000;

	localparam logic [FIELD_CH_BITS-1:0] FAILSAFE_CHANNEL = 4'd2;
	localparam logic signed [VALUE_BITS-1:0] FAILSAFE_VALUE = -13'sd500;

	typedef enum logic [1:0] {
		KIND_CHANNEL  = 2'd0,
		KIND_LOST     = 2'd1,
		KIND_FAILSAFE = 2'd2
	} kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SYNC   = 2'd0,
		REG_LOST   = 2'd1,
		REG_ZERO   = 2'd2,
		REG_PERIOD = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                   accept;
		logic                   load;
		kind_t                  kind;
		logic [CH_IDX_BITS-1:0] idx;
		logic                   last;
	} rppm_cmd_t;

	typedef struct packed {
		logic frame_good;
		logic frame_lost;
		logic fail;
		logic out_free;
	} rppm_sts_t;

endpackage

// ----- rtl/core/rppm_ctrl.sv -----
// Controller: accepts samples and sequences the result beats of one tick.
`include "assert_macros.svh"

module rppm_ctrl
	import rppm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      sample_valid,
	output logic      sample_ready,
	input  rppm_sts_t st,
	output rppm_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHAN,
		S_LOST,
		S_FAIL
	} state_t;

	state_t                 state_q;
	logic [CH_IDX_BITS-1:0] idx_q;
	logic                   fs_pend_q;

	assign sample_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.accept = sample_ready && sample_valid;
		cmd.load   = (state_q != S_IDLE) && st.out_free;
		cmd.idx    = idx_q;
		unique case (state_q)
			S_CHAN: begin
				cmd.kind = KIND_CHANNEL;
				cmd.last = (idx_q == CH_LAST) && !fs_pend_q;
			end
			S_LOST: begin
				cmd.kind = KIND_LOST;
				cmd.last = !fs_pend_q;
			end
			S_FAIL: begin
				cmd.kind = KIND_FAILSAFE;
				cmd.last = 1'b1;
			end
			default: begin
				cmd.kind = KIND_CHANNEL;
				cmd.last = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			fs_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						idx_q     <= '0;
						fs_pend_q <= st.fail;
						if (st.frame_good)
							state_q <= S_CHAN;
						else if (st.frame_lost)
							state_q <= S_LOST;
						else if (st.fail)
							state_q <= S_FAIL;
					end
				end
				S_CHAN: begin
					if (cmd.load) begin
						idx_q <= idx_q + 1'b1;
						if (idx_q == CH_LAST)
							state_q <= fs_pend_q ? S_FAIL : S_IDLE;
					end
				end
				S_LOST: begin
					if (cmd.load)
						state_q <= fs_pend_q ? S_FAIL : S_IDLE;
				end
				S_FAIL: begin
					if (cmd.load) begin
						fs_pend_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`ASSERT_PROP(a_last_to_idle, (cmd.load && cmd.last) |=> (state_q == S_IDLE), "last beat did not end the run")
	`ASSERT_PROP(a_good_starts_ch0, (cmd.accept && st.frame_good) |=> (state_q == S_CHAN && idx_q == '0), "good frame did not start at channel 0")
	`ASSERT_NEVER(a_good_no_fail, cmd.accept && st.frame_good && st.fail, "failsafe raised on a good frame")

endmodule

// ----- rtl/core/rppm_dpath.sv -----
// Datapath: interval timing, channel store, watchdog and result register.
`include "assert_macros.svh"

module rppm_dpath
	import rppm_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            pin_level,
	input  logic                            cfg_we,
	input  logic [CFG_IDX_BITS-1:0]         cfg_index,
	input  logic [CFG_DATA_BITS-1:0]        cfg_data,
	input  rppm_cmd_t                       cmd,
	output rppm_sts_t                       st,
	output logic                            result_valid,
	input  logic                            result_ready,
	output logic [1:0]                      result_kind,
	output logic [FIELD_CH_BITS-1:0]        channel_index,
	output logic signed [VALUE_BITS-1:0]    channel_value,
	output logic [FIELD_CH_BITS-1:0]        channel_count,
	output logic                            last
);

	logic [15:0]             sync_q;
	logic [15:0]             lost_q;
	logic [STORE_BITS-1:0]   zero_q;
	logic [WD_BITS-1:0]      period_q;

	logic                    prev_q;
	logic                    run_q;
	logic [COUNTER_BITS-1:0] ic_q;
	logic [STORE_BITS-1:0]   store_q [MAX_CHANNELS];
	logic [CH_IDX_BITS-1:0]  ptr_q;
	logic [FIELD_CH_BITS-1:0] cnt_q;
	logic [WD_BITS-1:0]      wd_q;
	logic                    good_q;

	logic                    valid_q;
	kind_t                   kind_q;
	logic [FIELD_CH_BITS-1:0] idx_q;
	logic signed [VALUE_BITS-1:0] val_q;
	logic [FIELD_CH_BITS-1:0] count_q;
	logic                    last_q;

	logic [COUNTER_BITS-1:0] ic_inc;
	logic                    fall;
	logic                    is_sync;
	logic                    is_lost;
	logic [STORE_BITS-1:0]   store_val;
	logic [CH_IDX_BITS-1:0]  ptr_nxt;
	logic [WD_BITS-1:0]      wd_inc;
	logic                    wd_fire;
	logic [STORE_BITS-1:0]   rd_width;
	logic signed [VALUE_BITS-1:0] chan_val;

	always_comb begin
		ic_inc    = (run_q && ic_q != CNT_MAX) ? ic_q + 1'b1 : ic_q;
		fall      = prev_q && !pin_level;
		is_sync   = CMP_BITS'(ic_inc) >= CMP_BITS'(sync_q);
		is_lost   = CMP_BITS'(ic_inc) >= CMP_BITS'(lost_q);
		store_val = (CMP_BITS'(ic_inc) > CMP_BITS'(STORE_MAX)) ? STORE_MAX
			: ic_inc[STORE_BITS-1:0];
		ptr_nxt   = (ptr_q == CH_LAST) ? '0 : ptr_q + 1'b1;
		wd_inc    = wd_q + 1'b1;
		wd_fire   = wd_inc >= period_q;
		rd_width  = store_q[cmd.idx];
		chan_val  = $signed({1'b0, rd_width}) - $signed({1'b0, zero_q});

		st.frame_good = fall && is_sync && !is_lost;
		st.frame_lost = fall && is_sync && is_lost;
		st.fail       = wd_fire && !(good_q || st.frame_good);
		st.out_free   = !valid_q || result_ready;
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q   <= SYNC_RST;
			lost_q   <= LOST_RST;
			zero_q   <= ZERO_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SYNC:   sync_q   <= cfg_data[15:0];
				REG_LOST:   lost_q   <= cfg_data[15:0];
				REG_ZERO:   zero_q   <= cfg_data[STORE_BITS-1:0];
				REG_PERIOD: period_q <= cfg_data[WD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// per-tick state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= 1'b1;
			run_q  <= 1'b0;
			ic_q   <= '0;
			ptr_q  <= '0;
			cnt_q  <= '0;
			wd_q   <= '0;
			good_q <= 1'b0;
			for (int i = 0; i < MAX_CHANNELS; i++)
				store_q[i] <= '0;
		end else if (cmd.accept) begin
			prev_q <= pin_level;
			if (fall) begin
				ic_q  <= '0;
				run_q <= 1'b1;
				if (is_sync) begin
					cnt_q <= FIELD_CH_BITS'(ptr_q);
					ptr_q <= '0;
				end else begin
					store_q[ptr_q] <= store_val;
					ptr_q          <= ptr_nxt;
				end
			end else begin
				ic_q <= ic_inc;
			end
			if (wd_fire) begin
				wd_q   <= '0;
				good_q <= 1'b0;
			end else begin
				wd_q <= wd_inc;
				if (st.frame_good)
					good_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (cmd.load)
			valid_q <= 1'b1;
		else if (result_ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= cmd.kind;
			last_q <= cmd.last;
			unique case (cmd.kind)
				KIND_CHANNEL: begin
					idx_q   <= FIELD_CH_BITS'(cmd.idx);
					val_q   <= chan_val;
					count_q <= cnt_q;
				end
				KIND_FAILSAFE: begin
					idx_q   <= FAILSAFE_CHANNEL;
					val_q   <= FAILSAFE_VALUE;
					count_q <= '0;
				end
				default: begin
					idx_q   <= '0;
					val_q   <= '0;
					count_q <= '0;
				end
			endcase
		end
	end

	assign result_valid  = valid_q;
	assign result_kind   = kind_q;
	assign channel_index = idx_q;
	assign channel_value = val_q;
	assign channel_count = count_q;
	assign last          = last_q;

	`ASSERT_NEVER(a_ptr_range, ptr_q > CH_LAST, "channel pointer out of range")

endmodule

// ----- rtl/core/rc_ppm_frame_decoder.sv -----
// Top level of the RC PPM frame decoder.
//
// Usage:
//   sample channel (sample_valid/sample_ready, pin_level): one beat per
//   microsecond tick carrying the sampled PPM line level.
//   result channel (result_valid/result_ready): channel values, lost-frame
//   and failsafe beats; last marks the final beat caused by one sample.
//   cfg_we/cfg_index/cfg_data: register write, one per cycle, no wait.
// Throughput: a sample that causes no result is taken every cycle. A sample
//   that ends a good frame holds sample_ready low while the sequencer walks
//   the sixteen stored channels, one per cycle while the output is free. A
//   lost frame, a failsafe beat or both together hold it low until loaded.
// An accepted sample sets the controller state; the first result beat is then loaded into the result register.
// The next sample is taken as soon as the last result sits in the output
//   register, even if the receiver has not yet taken it.
// A stalled receiver pauses the sequencer; nothing is dropped.
// Reset: registers return to their defaults, the channel store clears,
//   the line is assumed idle high and the watchdog restarts from zero.
module rc_ppm_frame_decoder
	import rppm_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         sample_valid,
	output logic                         sample_ready,
	input  logic                         pin_level,
	output logic                         result_valid,
	input  logic                         result_ready,
	output logic [1:0]                   result_kind,
	output logic [FIELD_CH_BITS-1:0]     channel_index,
	output logic signed [VALUE_BITS-1:0] channel_value,
	output logic [FIELD_CH_BITS-1:0]     channel_count,
	output logic                         last,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

	rppm_cmd_t cmd;
	rppm_sts_t st;

	rppm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.st           (st),
		.cmd          (cmd)
	);

	rppm_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.pin_level     (pin_level),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (cmd),
		.st            (st),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.result_kind   (result_kind),
		.channel_index (channel_index),
		.channel_value (channel_value),
		.channel_count (channel_count),
		.last          (last)
	);

endmodule
